FILE: rtl/core/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
package cfr_pkg;

  localparam int FRAME_LENGTH = 11;
  localparam int POS_W        = 4;

  localparam logic [POS_W-1:0] POS_IDLE  = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_W-1:0] CHECK_POS = 4'd9;
  localparam logic [POS_W-1:0] TAIL_POS  = 4'd10;
  localparam logic [POS_W-1:0] FRAME_LEN = 4'd11;

  localparam logic [7:0] CFG_HEADER = 8'd0;
  localparam logic [7:0] CFG_TAIL   = 8'd1;

  localparam logic [7:0] HEADER_RESET = 8'd123;
  localparam logic [7:0] TAIL_RESET   = 8'd125;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_SUM  = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t      status;
    logic [7:0]         flag;
    logic [7:0]         spare;
    logic signed [15:0] x_tgt;
    logic signed [15:0] y_tgt;
    logic signed [15:0] z_tgt;
  } frame_result_t;

endpackage

FILE: rtl/core/cfr_input_stage.sv
// Input holding register for received bytes.
module cfr_input_stage import cfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       byte_take
);

  logic       held;
  logic [7:0] held_byte;
  logic       accept;

  assign in_stall   = held && !byte_take;
  assign accept     = in_valid && !in_stall;
  assign byte_valid = held;
  assign byte_data  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (byte_take) begin
      held <= 1'b0;
    end
  end

  // load a new word; hold it otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

FILE: rtl/core/cfr_frame_collect.sv
// Frame position tracking, byte store, running XOR and result build.
module cfr_frame_collect import cfr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  input  logic [7:0]    byte_data,
  output logic          byte_take,
  input  logic          result_room,
  input  logic [7:0]    header_byte,
  input  logic [7:0]    tail_byte,
  output logic          result_load,
  output frame_result_t result
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       frame_store [1:9];
  logic             idle;
  logic             completes;

  assign idle      = (byte_position == POS_IDLE) || (byte_position >= FRAME_LEN);
  assign completes = !idle && (byte_position == TAIL_POS);
  assign byte_take   = byte_valid && (!completes || result_room);
  assign result_load = byte_take && completes;

  always_comb begin
    byte_position_next = byte_position;
    running_xor_next   = running_xor;
    if (byte_take) begin
      if (idle) begin
        if (byte_data == header_byte) begin
          byte_position_next = POS_FIRST;
          running_xor_next   = byte_data;
        end else begin
          byte_position_next = POS_IDLE;
        end
      end else if (completes) begin
        byte_position_next = POS_IDLE;
      end else begin
        byte_position_next = byte_position + POS_FIRST;
        if (byte_position < CHECK_POS) begin
          running_xor_next = running_xor ^ byte_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      running_xor   <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      running_xor   <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= 9; i++) begin
      if (byte_take && !idle && (byte_position == POS_W'(i))) begin
        frame_store[i] <= byte_data;
      end
    end
  end

  // the tail byte is the incoming word itself
  always_comb begin
    if (byte_data != tail_byte) begin
      result.status = STATUS_BAD_TAIL;
    end else if (frame_store[9] != running_xor) begin
      result.status = STATUS_BAD_SUM;
    end else begin
      result.status = STATUS_OK;
    end
    result.flag  = frame_store[1];
    result.spare = frame_store[2];
    result.x_tgt = {frame_store[3], frame_store[4]};
    result.y_tgt = {frame_store[5], frame_store[6]};
    result.z_tgt = {frame_store[7], frame_store[8]};
  end

endmodule

FILE: rtl/core/cfr_result_reg.sv
// Output result register with valid/stall handshake.
module cfr_result_reg import cfr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          result_load,
  input  frame_result_t result,
  output logic          result_room,
  output logic          out_valid,
  input  logic          out_stall,
  output frame_result_t out_result
);

  logic full;

  assign result_room = !full || !out_stall;
  assign out_valid   = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (result_load) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_result <= result;
    end
  end

endmodule

FILE: rtl/core/command_frame_receiver.sv
// Top level of the command frame receiver: deframes header/tail/XOR-checked frames.
//
//   channel   direction  handshake             payload
//   in        to block   in_valid / in_stall   rx_byte
//   out       from block out_valid / out_stall frame_status, flag_field, spare_field,
//                                              x_target, y_target, z_target
//   cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is taken every cycle unless in_stall is raised; a word is held in the input
// register until the frame logic takes it, and a frame's result is registered in the
// result register once its tail word is taken. The rate is set by the single input
// register feeding the frame logic. rst (synchronous) clears the frame position,
// the running XOR and both valid flags and restores the header and tail values.
// A stalled output only blocks the tail word of the next frame; all other words
// keep flowing past a waiting result.
module command_frame_receiver import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // received bytes
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  // frame results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_status,
  output logic [7:0]         flag_field,
  output logic [7:0]         spare_field,
  output logic signed [15:0] x_target,
  output logic signed [15:0] y_target,
  output logic signed [15:0] z_target,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic          byte_valid;
  logic [7:0]    byte_data;
  logic          byte_take;
  logic          result_room;
  logic          result_load;
  frame_result_t result;
  frame_result_t out_result;
  logic [7:0]    header_byte;
  logic [7:0]    tail_byte;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      tail_byte   <= TAIL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER: header_byte <= cfg_data;
        CFG_TAIL:   tail_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold each incoming word until the frame logic takes it.
  cfr_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  // Advance the frame position, store bytes, fold the checksum, build the result.
  cfr_frame_collect u_collect (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_data   (byte_data),
    .byte_take   (byte_take),
    .result_room (result_room),
    .header_byte (header_byte),
    .tail_byte   (tail_byte),
    .result_load (result_load),
    .result      (result)
  );

  // Park the finished result until the consumer takes it.
  cfr_result_reg u_result (
    .clk         (clk),
    .rst         (rst),
    .result_load (result_load),
    .result      (result),
    .result_room (result_room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  assign frame_status = out_result.status;
  assign flag_field   = out_result.flag;
  assign spare_field  = out_result.spare;
  assign x_target     = out_result.x_tgt;
  assign y_target     = out_result.y_tgt;
  assign z_target     = out_result.z_tgt;

endmodule
